// File: sv/csm_pkg.sv
// Shared types for the collinear segment merge block.
// No dependencies; imported by csm_merge and collinear_segment_merge.
package csm_pkg;

  typedef enum logic [1:0] {
    KIND_OPEN,
    KIND_PASS,
    KIND_MID,
    KIND_CLOSE
  } kind_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } stage_ctrl_t;

endpackage

// File: sv/collinear_segment_merge.sv
// Top level of the collinear segment merge block: run tracking, two projection lanes, merge.
// Depends on csm_pkg, csm_lane and csm_merge.
//
// Usage: one segment per input item (start/stop point, last flag), signed Q15.8
// coordinates. The first segment of a run sets origin and axis; each endpoint is
// projected onto the axis and the min/max endpoints are tracked. The item with
// last_i set produces one output item: the merged segment. A run of one segment
// comes out unchanged.
// Throughput: one item per cycle while the input is not stalled. Each endpoint has its
// own lane (register, multiply, add), and the merge stage compares both lane results.
// Path: each item passes lane stages a, b and c, then the merge result register.
// Stall: out_stall_i holds the result register; items that produce no result keep
// flowing. Input stalls only when all three lane stages are full and the head
// item needs the result register that is still held.
// Reset: clears the pipeline and result valid; the next segment opens a new run.
module collinear_segment_merge import csm_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COORD_WIDTH-1:0] start_x_i,
  input  logic [COORD_WIDTH-1:0] start_y_i,
  input  logic [COORD_WIDTH-1:0] stop_x_i,
  input  logic [COORD_WIDTH-1:0] stop_y_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [COORD_WIDTH-1:0] merged_start_x_o,
  output logic [COORD_WIDTH-1:0] merged_start_y_o,
  output logic [COORD_WIDTH-1:0] merged_stop_x_o,
  output logic [COORD_WIDTH-1:0] merged_stop_y_o
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int SW = 2 * DW + 1;

  logic first_pending_q;
  logic [W-1:0] origin_x_q, origin_y_q;
  logic signed [DW-1:0] axis_x_q, axis_y_q;
  logic signed [DW-1:0] sx_e, sy_e, ex_e, ey_e, ox_e, oy_e;
  logic signed [DW-1:0] new_ax, new_ay, lane_ax, lane_ay;
  logic signed [DW-1:0] ds_x, ds_y, de_x, de_y;
  kind_e in_kind;
  stage_ctrl_t ctrl_a_q, ctrl_b_q, ctrl_c_q;
  logic adv_a, adv_b, adv_c, in_acc;
  logic signed [SW-1:0] proj_s, proj_e;
  logic [W-1:0] s_x, s_y, e_x, e_y;

  assign sx_e   = $signed({start_x_i[W-1], start_x_i});
  assign sy_e   = $signed({start_y_i[W-1], start_y_i});
  assign ex_e   = $signed({stop_x_i[W-1], stop_x_i});
  assign ey_e   = $signed({stop_y_i[W-1], stop_y_i});
  assign ox_e   = $signed({origin_x_q[W-1], origin_x_q});
  assign oy_e   = $signed({origin_y_q[W-1], origin_y_q});
  assign new_ax = ex_e - sx_e;
  assign new_ay = ey_e - sy_e;

  always_comb begin
    if (first_pending_q) begin
      in_kind = last_i ? KIND_PASS : KIND_OPEN;
      lane_ax = new_ax;
      lane_ay = new_ay;
      ds_x    = '0;
      ds_y    = '0;
      de_x    = new_ax;
      de_y    = new_ay;
    end else begin
      in_kind = last_i ? KIND_CLOSE : KIND_MID;
      lane_ax = axis_x_q;
      lane_ay = axis_y_q;
      ds_x    = sx_e - ox_e;
      ds_y    = sy_e - oy_e;
      de_x    = ex_e - ox_e;
      de_y    = ey_e - oy_e;
    end
  end

  assign adv_b      = !ctrl_b_q.valid || adv_c;
  assign adv_a      = !ctrl_a_q.valid || adv_b;
  assign in_stall_o = !adv_a;
  assign in_acc     = in_valid_i && adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pending_q <= 1'b1;
      ctrl_a_q        <= '0;
      ctrl_b_q        <= '0;
      ctrl_c_q        <= '0;
    end else begin
      if (in_acc) begin
        first_pending_q <= last_i;
      end
      if (adv_a) begin
        ctrl_a_q.valid <= in_valid_i;
        ctrl_a_q.kind  <= in_kind;
      end
      if (adv_b) begin
        ctrl_b_q <= ctrl_a_q;
      end
      if (adv_c) begin
        ctrl_c_q <= ctrl_b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && first_pending_q && !last_i) begin
      origin_x_q <= start_x_i;
      origin_y_q <= start_y_i;
      axis_x_q   <= new_ax;
      axis_y_q   <= new_ay;
    end
  end

  csm_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_start (
    .clk_i     (clk_i),
    .load_a_i  (in_acc),
    .load_b_i  (adv_b && ctrl_a_q.valid),
    .load_c_i  (adv_c && ctrl_b_q.valid),
    .point_x_i (start_x_i),
    .point_y_i (start_y_i),
    .diff_x_i  (ds_x),
    .diff_y_i  (ds_y),
    .axis_x_i  (lane_ax),
    .axis_y_i  (lane_ay),
    .point_x_o (s_x),
    .point_y_o (s_y),
    .proj_o    (proj_s)
  );

  csm_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_stop (
    .clk_i     (clk_i),
    .load_a_i  (in_acc),
    .load_b_i  (adv_b && ctrl_a_q.valid),
    .load_c_i  (adv_c && ctrl_b_q.valid),
    .point_x_i (stop_x_i),
    .point_y_i (stop_y_i),
    .diff_x_i  (de_x),
    .diff_y_i  (de_y),
    .axis_x_i  (lane_ax),
    .axis_y_i  (lane_ay),
    .point_x_o (e_x),
    .point_y_o (e_y),
    .proj_o    (proj_e)
  );

  csm_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl_c_q),
    .proj_s_i         (proj_s),
    .proj_e_i         (proj_e),
    .s_x_i            (s_x),
    .s_y_i            (s_y),
    .e_x_i            (e_x),
    .e_y_i            (e_y),
    .out_stall_i      (out_stall_i),
    .ready_o          (adv_c),
    .out_valid_o      (out_valid_o),
    .merged_start_x_o (merged_start_x_o),
    .merged_start_y_o (merged_start_y_o),
    .merged_stop_x_o  (merged_stop_x_o),
    .merged_stop_y_o  (merged_stop_y_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && ctrl_c_q.valid))
    else $error("input stalled without a held result");

  a_run_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_i) |=> first_pending_q)
    else $error("run not closed after last item");

  a_run_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !last_i) |=> !first_pending_q)
    else $error("run not open after non-last item");

endmodule

// File: sv/csm_lane.sv
// One projection lane: diff/axis register, two products, sum of products.
// Carries its endpoint alongside. No package dependency.
module csm_lane #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           load_a_i,
  input  logic                           load_b_i,
  input  logic                           load_c_i,
  input  logic        [COORD_WIDTH-1:0]  point_x_i,
  input  logic        [COORD_WIDTH-1:0]  point_y_i,
  input  logic signed [COORD_WIDTH:0]    diff_x_i,
  input  logic signed [COORD_WIDTH:0]    diff_y_i,
  input  logic signed [COORD_WIDTH:0]    axis_x_i,
  input  logic signed [COORD_WIDTH:0]    axis_y_i,
  output logic        [COORD_WIDTH-1:0]  point_x_o,
  output logic        [COORD_WIDTH-1:0]  point_y_o,
  output logic signed [2*COORD_WIDTH+2:0] proj_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] ax_q, ay_q, dx_q, dy_q;
  logic [COORD_WIDTH-1:0] pxa_q, pya_q, pxb_q, pyb_q, pxc_q, pyc_q;
  logic signed [PW-1:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [SW-1:0] proj_d, proj_q;

  assign prod_x_d = $signed({{DW{ax_q[DW-1]}}, ax_q}) * $signed({{DW{dx_q[DW-1]}}, dx_q});
  assign prod_y_d = $signed({{DW{ay_q[DW-1]}}, ay_q}) * $signed({{DW{dy_q[DW-1]}}, dy_q});
  assign proj_d   = $signed({prod_x_q[PW-1], prod_x_q}) + $signed({prod_y_q[PW-1], prod_y_q});

  always_ff @(posedge clk_i) begin
    if (load_a_i) begin
      ax_q  <= axis_x_i;
      ay_q  <= axis_y_i;
      dx_q  <= diff_x_i;
      dy_q  <= diff_y_i;
      pxa_q <= point_x_i;
      pya_q <= point_y_i;
    end
    if (load_b_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      pxb_q    <= pxa_q;
      pyb_q    <= pya_q;
    end
    if (load_c_i) begin
      proj_q <= proj_d;
      pxc_q  <= pxb_q;
      pyc_q  <= pyb_q;
    end
  end

  assign point_x_o = pxc_q;
  assign point_y_o = pyc_q;
  assign proj_o    = proj_q;

endmodule

// File: sv/csm_merge.sv
// Merge stage: folds both lane projections into running min/max, drives result register.
// Depends on csm_pkg (kind_e, stage_ctrl_t).
module csm_merge import csm_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  stage_ctrl_t                     ctrl_i,
  input  logic signed [2*COORD_WIDTH+2:0] proj_s_i,
  input  logic signed [2*COORD_WIDTH+2:0] proj_e_i,
  input  logic        [COORD_WIDTH-1:0]   s_x_i,
  input  logic        [COORD_WIDTH-1:0]   s_y_i,
  input  logic        [COORD_WIDTH-1:0]   e_x_i,
  input  logic        [COORD_WIDTH-1:0]   e_y_i,
  input  logic                            out_stall_i,
  output logic                            ready_o,
  output logic                            out_valid_o,
  output logic        [COORD_WIDTH-1:0]   merged_start_x_o,
  output logic        [COORD_WIDTH-1:0]   merged_start_y_o,
  output logic        [COORD_WIDTH-1:0]   merged_stop_x_o,
  output logic        [COORD_WIDTH-1:0]   merged_stop_y_o
);

  localparam int SW = 2 * COORD_WIDTH + 3;

  logic signed [SW-1:0] low_proj_q, high_proj_q, low_proj_d, high_proj_d;
  logic signed [SW-1:0] base_lo, base_hi;
  logic [COORD_WIDTH-1:0] low_x_q, low_y_q, high_x_q, high_y_q;
  logic [COORD_WIDTH-1:0] low_x_d, low_y_d, high_x_d, high_y_d;
  logic [COORD_WIDTH-1:0] base_lo_x, base_lo_y, base_hi_x, base_hi_y;
  logic s_lo, e_lo_base, e_lo_s, end_lo;
  logic s_hi, e_hi_base, e_hi_s, end_hi;
  logic out_valid_q, out_free, has_result, fire;

  always_comb begin
    has_result = 1'b0;
    base_lo    = low_proj_q;
    base_hi    = high_proj_q;
    base_lo_x  = low_x_q;
    base_lo_y  = low_y_q;
    base_hi_x  = high_x_q;
    base_hi_y  = high_y_q;
    unique case (ctrl_i.kind)
      KIND_OPEN: begin
        base_lo   = '0;
        base_hi   = '0;
        base_lo_x = s_x_i;
        base_lo_y = s_y_i;
        base_hi_x = s_x_i;
        base_hi_y = s_y_i;
      end
      KIND_PASS:  has_result = 1'b1;
      KIND_MID:   has_result = 1'b0;
      KIND_CLOSE: has_result = 1'b1;
      default:    has_result = 1'b0;
    endcase
  end

  // start is considered before end; strict compares keep the earliest point on ties
  always_comb begin
    s_lo      = proj_s_i < base_lo;
    e_lo_base = proj_e_i < base_lo;
    e_lo_s    = proj_e_i < proj_s_i;
    end_lo    = s_lo ? e_lo_s : e_lo_base;
    s_hi      = proj_s_i > base_hi;
    e_hi_base = proj_e_i > base_hi;
    e_hi_s    = proj_e_i > proj_s_i;
    end_hi    = s_hi ? e_hi_s : e_hi_base;

    low_proj_d = base_lo;
    low_x_d    = base_lo_x;
    low_y_d    = base_lo_y;
    if (end_lo) begin
      low_proj_d = proj_e_i;
      low_x_d    = e_x_i;
      low_y_d    = e_y_i;
    end else if (s_lo) begin
      low_proj_d = proj_s_i;
      low_x_d    = s_x_i;
      low_y_d    = s_y_i;
    end

    high_proj_d = base_hi;
    high_x_d    = base_hi_x;
    high_y_d    = base_hi_y;
    if (end_hi) begin
      high_proj_d = proj_e_i;
      high_x_d    = e_x_i;
      high_y_d    = e_y_i;
    end else if (s_hi) begin
      high_proj_d = proj_s_i;
      high_x_d    = s_x_i;
      high_y_d    = s_y_i;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign ready_o  = !ctrl_i.valid || !has_result || out_free;
  assign fire     = ctrl_i.valid && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      low_proj_q  <= '0;
      high_proj_q <= '0;
    end else begin
      if (fire && has_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire && ctrl_i.kind != KIND_PASS) begin
        low_proj_q  <= low_proj_d;
        high_proj_q <= high_proj_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && ctrl_i.kind != KIND_PASS) begin
      low_x_q  <= low_x_d;
      low_y_q  <= low_y_d;
      high_x_q <= high_x_d;
      high_y_q <= high_y_d;
    end
    if (fire && has_result) begin
      if (ctrl_i.kind == KIND_PASS) begin
        merged_start_x_o <= s_x_i;
        merged_start_y_o <= s_y_i;
        merged_stop_x_o  <= e_x_i;
        merged_stop_y_o  <= e_y_i;
      end else begin
        merged_start_x_o <= low_x_d;
        merged_start_y_o <= low_y_d;
        merged_stop_x_o  <= high_x_d;
        merged_stop_y_o  <= high_y_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_lo_le_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_proj_q <= high_proj_q)
    else $error("running min projection above running max");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && has_result) |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

endmodule
